FILE: src/sufe_pkg.sv
// Shared types, constants and the CRC-8 byte update for the stepper UART frame encoder.
// No dependencies.
package sufe_pkg;

    localparam int unsigned FIFO_DEPTH_DEFAULT = 2;

    localparam logic [7:0] READ_SYNC_RESET  = 8'h55;
    localparam logic [7:0] WRITE_SYNC_RESET = 8'h05;
    localparam logic [7:0] NODE_ADDR_RESET  = 8'h00;

    localparam logic [7:0] CRC_POLY   = 8'h07;
    localparam logic [7:0] WRITE_FLAG = 8'h80;

    // Configuration register indexes
    localparam logic [1:0] CFG_READ_SYNC  = 2'd0;
    localparam logic [1:0] CFG_WRITE_SYNC = 2'd1;
    localparam logic [1:0] CFG_NODE_ADDR  = 2'd2;

    // Byte positions in a datagram
    localparam logic [2:0] READ_LAST_IDX  = 3'd3;
    localparam logic [2:0] WRITE_LAST_IDX = 3'd7;

    // One classified request: everything the back end needs to emit the datagram.
    typedef struct packed {
        logic        is_write;
        logic [7:0]  sync_byte;
        logic [7:0]  node_byte;
        logic [7:0]  addr_byte;
        logic [31:0] value;
    } sufe_desc_t;

    // Feed one byte LSB first into the CRC register, examined at its MSB.
    function automatic logic [7:0] crc8_update(input logic [7:0] crc_in,
                                               input logic [7:0] data_in);
        logic [7:0] acc;
        logic [7:0] cur;
        acc = crc_in;
        cur = data_in;
        for (int b = 0; b < 8; b++) begin
            if (acc[7] ^ cur[0]) begin
                acc = {acc[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                acc = {acc[6:0], 1'b0};
            end
            cur = {1'b0, cur[7:1]};
        end
        return acc;
    endfunction

endpackage

FILE: src/sufe_front.sv
// Front end: configuration registers, request intake and classification into a descriptor.
// Depends on sufe_pkg.
module sufe_front import sufe_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        in_operation,
    input  logic [6:0]  in_reg_address,
    input  logic [31:0] in_write_value,
    output logic        desc_valid,
    input  logic        desc_ready,
    output sufe_desc_t  desc
);

    logic [7:0] read_sync_reg,  read_sync_next;
    logic [7:0] write_sync_reg, write_sync_next;
    logic [7:0] node_addr_reg,  node_addr_next;
    logic       valid_reg,      valid_next;
    sufe_desc_t desc_reg,       desc_next;

    assign in_ready   = !valid_reg || desc_ready;
    assign desc_valid = valid_reg;
    assign desc       = desc_reg;

    always_comb begin
        read_sync_next  = read_sync_reg;
        write_sync_next = write_sync_reg;
        node_addr_next  = node_addr_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_READ_SYNC:  read_sync_next  = cfg_data;
                CFG_WRITE_SYNC: write_sync_next = cfg_data;
                CFG_NODE_ADDR:  node_addr_next  = cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        valid_next = valid_reg;
        desc_next  = desc_reg;
        if (desc_ready) begin
            valid_next = 1'b0;
        end
        if (in_valid && in_ready) begin
            valid_next         = 1'b1;
            desc_next.is_write = in_operation;
            desc_next.sync_byte = in_operation ? write_sync_reg : read_sync_reg;
            desc_next.node_byte = node_addr_reg;
            desc_next.addr_byte = in_operation ? (WRITE_FLAG | {1'b0, in_reg_address})
                                               : {1'b0, in_reg_address};
            desc_next.value    = in_write_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            read_sync_reg  <= READ_SYNC_RESET;
            write_sync_reg <= WRITE_SYNC_RESET;
            node_addr_reg  <= NODE_ADDR_RESET;
            valid_reg      <= 1'b0;
        end else begin
            read_sync_reg  <= read_sync_next;
            write_sync_reg <= write_sync_next;
            node_addr_reg  <= node_addr_next;
            valid_reg      <= valid_next;
        end
        desc_reg <= desc_next;
    end

endmodule

FILE: src/sufe_queue.sv
// Short descriptor queue between front and back end.
// Depends on sufe_pkg.
module sufe_queue import sufe_pkg::*; #(
    parameter int unsigned DEPTH = FIFO_DEPTH_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       wr_valid,
    output logic       wr_ready,
    input  sufe_desc_t wr_desc,
    output logic       rd_valid,
    input  logic       rd_ready,
    output sufe_desc_t rd_desc
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    sufe_desc_t       mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             push, pop;

    assign wr_ready = (count_reg != CNT_FULL);
    assign rd_valid = (count_reg != '0);
    assign rd_desc  = mem[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            mem[wr_ptr_reg] <= wr_desc;
        end
    end

endmodule

FILE: src/sufe_back.sv
// Back end: walks one descriptor byte by byte, folds each byte into the CRC,
// and drives the registered output stage. Depends on sufe_pkg.
module sufe_back import sufe_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       desc_valid,
    output logic       desc_ready,
    input  sufe_desc_t desc,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       out_last
);

    sufe_desc_t cur_reg,      cur_next;
    logic       busy_reg,     busy_next;
    logic [2:0] idx_reg,      idx_next;
    logic [7:0] crc_reg,      crc_next;
    logic       oval_reg,     oval_next;
    logic [7:0] obyte_reg,    obyte_next;
    logic       olast_reg,    olast_next;

    logic       slot_free, emit, at_last;
    logic [2:0] last_idx;
    logic [7:0] body_byte, emit_byte;

    assign out_valid = oval_reg;
    assign out_byte  = obyte_reg;
    assign out_last  = olast_reg;

    assign slot_free  = !oval_reg || out_ready;
    assign emit       = busy_reg && slot_free;
    assign last_idx   = cur_reg.is_write ? WRITE_LAST_IDX : READ_LAST_IDX;
    assign at_last    = (idx_reg == last_idx);
    assign desc_ready = !busy_reg || (emit && at_last);

    always_comb begin
        case (idx_reg)
            3'd0:    body_byte = cur_reg.sync_byte;
            3'd1:    body_byte = cur_reg.node_byte;
            3'd2:    body_byte = cur_reg.addr_byte;
            3'd3:    body_byte = cur_reg.value[31:24];
            3'd4:    body_byte = cur_reg.value[23:16];
            3'd5:    body_byte = cur_reg.value[15:8];
            3'd6:    body_byte = cur_reg.value[7:0];
            default: body_byte = cur_reg.value[7:0];
        endcase
        emit_byte = at_last ? crc_reg : body_byte;
    end

    always_comb begin
        cur_next   = cur_reg;
        busy_next  = busy_reg;
        idx_next   = idx_reg;
        crc_next   = crc_reg;
        oval_next  = oval_reg;
        obyte_next = obyte_reg;
        olast_next = olast_reg;

        if (out_ready) begin
            oval_next = 1'b0;
        end
        if (emit) begin
            oval_next  = 1'b1;
            obyte_next = emit_byte;
            olast_next = at_last;
            crc_next   = crc8_update(crc_reg, emit_byte);
            idx_next   = idx_reg + 1'b1;
            if (at_last) begin
                busy_next = 1'b0;
            end
        end
        if (desc_valid && desc_ready) begin
            cur_next  = desc;
            busy_next = 1'b1;
            idx_next  = '0;
            crc_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            oval_reg <= 1'b0;
            idx_reg  <= '0;
            crc_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            oval_reg <= oval_next;
            idx_reg  <= idx_next;
            crc_reg  <= crc_next;
        end
        cur_reg   <= cur_next;
        obyte_reg <= obyte_next;
        olast_reg <= olast_next;
    end

endmodule

FILE: src/stepper_uart_frame_encoder.sv
// Stepper-driver single-wire UART datagram encoder (read: 4 bytes, write: 8 bytes, CRC-8 last).
// A request passes the front-end register, the queue, the back-end descriptor register and the
// output register before its first byte shows on m_tvalid. Throughput: one byte per cycle
// while m_tready does not stall the output; datagrams follow one another with no gap bytes.
// Reset (aresetn, synchronous, active low): queue and pipeline empty, sync bytes 0x55/0x05,
// node address 0x00. Configuration is always ready.
module stepper_uart_frame_encoder import sufe_pkg::*; #(
    parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,

    // Configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,   // 0 read sync, 1 write sync, 2 node address
    input  logic [7:0]  cfg_data,

    // Request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,     // [6:0] reg_address, [38:7] write_value, [39] zero pad
    input  logic        s_tuser,     // [0] operation: 0 read, 1 write

    // Datagram byte stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,     // [7:0] frame_byte
    output logic        m_tlast      // last_byte: high on the CRC byte
);

    sufe_desc_t front_desc, queue_desc;
    logic       front_valid, front_ready;
    logic       queue_valid, queue_ready;

    // Config registers live in the front end and take every write to indexes 0 to 2 immediately; index 3 is ignored.
    assign cfg_ready = 1'b1;

    // Front end: latches the request and resolves sync byte, node and address byte.
    sufe_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .in_operation   (s_tuser),
        .in_reg_address (s_tdata[6:0]),
        .in_write_value (s_tdata[38:7]),
        .desc_valid     (front_valid),
        .desc_ready     (front_ready),
        .desc           (front_desc)
    );

    // Decouples intake from the byte-serial back end.
    sufe_queue #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .wr_desc  (front_desc),
        .rd_valid (queue_valid),
        .rd_ready (queue_ready),
        .rd_desc  (queue_desc)
    );

    // Back end: one byte per cycle unless m_tready stalls the output, CRC built on the fly, next datagram loaded
    // in the same cycle the CRC byte goes out.
    sufe_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .desc_valid (queue_valid),
        .desc_ready (queue_ready),
        .desc       (queue_desc),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_byte   (m_tdata),
        .out_last   (m_tlast)
    );

endmodule
